/* rtl/pds_pkg.sv */
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types, widths and constants of the PLL divider search.
// ----------------------------------------------------------------------------
package pds_pkg;

   localparam int TARGET_W = 12;
   localparam int SUM_W = 13;
   localparam int WANT_W = 19;
   localparam int X_W = 27;
   localparam int Y_W = X_W - 2;
   localparam int RECIP_W = 26;
   localparam int PROD_W = Y_W + RECIP_W;
   localparam int RECIP_SHIFT = 35;
   localparam int Q_W = 16;
   localparam int R_W = 13;
   localparam int FULL_W = 28;
   localparam int TRY_W = 3;
   localparam int PC_W = 5;

   localparam int DEF_MAX_DIVIDER = 128;
   localparam int DEF_MAX_MULTIPLIER = 254;
   localparam int DEF_TRY_COUNT = 4;

   localparam logic [RECIP_W-1:0] RECIP = 26'd54975581;
   localparam logic [R_W-1:0] MOD_CENTI = 13'd2500;
   localparam logic [WANT_W-1:0] CENTI = 19'd100;
   localparam logic [7:0] MIN_DIVIDER = 8'd2;

   localparam logic [PC_W-1:0] PC_IDLE = 5'd0;
   localparam logic [PC_W-1:0] PC_TRY = 5'd1;
   localparam logic [PC_W-1:0] PC_SCAN = 5'd12;
   localparam logic [PC_W-1:0] PC_HIT = 5'd16;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_NOP,
      OP_WANT,
      OP_X_WANT,
      OP_X_P0,
      OP_DIV_MUL,
      OP_DIV_REM,
      OP_DIV_FIX,
      OP_SAVE_STEP,
      OP_INIT_D,
      OP_SCAN,
      OP_NEXT_TRY,
      OP_HIT,
      OP_MISS
   } pds_op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_IDLE,
      COND_SCAN,
      COND_MATCH,
      COND_TRY
   } pds_cond_type;

   typedef struct packed {
      pds_op_type op;
      pds_cond_type cond;
      logic [PC_W-1:0] target;
   } pds_ctrl_type;

   typedef struct packed {
      logic match;
      logic more_d;
      logic more_try;
   } pds_flags_type;

endpackage

/* rtl/pll_divider_search.sv */
// ----------------------------------------------------------------------------
// pll_divider_search
// Finds the PLL multiplier and divider whose rounded-up output hits a target.
//
//   channel   ports                               transfer
//   request   start, busy, req_target_mhz         start high while busy low
//   response  rsp_strobe, rsp_pll_word, rsp_found one cycle with rsp_strobe high
//
// One request runs, for each attempted target, up to TRY_COUNT attempts, the
// target scaling, the two divisions by 2500 and the divider scan, and then
// issues the result, with the response in the cycle after the last busy cycle.
// The divider scan checks one divider per cycle in the shared remainder update.
// Reset clears the step counter and the response strobe.
// The response cannot be stalled; start is ignored while busy is high.
// ----------------------------------------------------------------------------
module pll_divider_search #(
   parameter int MAX_DIVIDER = pds_pkg::DEF_MAX_DIVIDER,
   parameter int MAX_MULTIPLIER = pds_pkg::DEF_MAX_MULTIPLIER,
   parameter int TRY_COUNT = pds_pkg::DEF_TRY_COUNT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [pds_pkg::TARGET_W-1:0]  req_target_mhz,
   output logic                          rsp_strobe,
   output logic [15:0]                   rsp_pll_word,
   output logic                          rsp_found
);
   import pds_pkg::*;

   pds_ctrl_type  ctrl;
   pds_flags_type flags;
   logic          accept;

   assign accept = start && !busy;

   pds_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .flags (flags),
      .ctrl  (ctrl),
      .busy  (busy)
   );

   pds_datapath #(
      .MAX_DIVIDER    (MAX_DIVIDER),
      .MAX_MULTIPLIER (MAX_MULTIPLIER),
      .TRY_COUNT      (TRY_COUNT)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .target_mhz   (req_target_mhz),
      .ctrl         (ctrl),
      .flags        (flags),
      .rsp_strobe   (rsp_strobe),
      .rsp_pll_word (rsp_pll_word),
      .rsp_found    (rsp_found)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after request transfer");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

   a_hit_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_found) |-> (rsp_pll_word[7:0] >= 8'd2 &&
                                     rsp_pll_word[15:8] != 8'd0))
      else $error("hit with invalid multiplier or divider");

   a_miss_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_found) |-> (rsp_pll_word == 16'd0))
      else $error("miss with nonzero word");

endmodule

/* rtl/pds_sequencer.sv */
// ----------------------------------------------------------------------------
// pds_sequencer
// Step counter and control store; one control word per step, conditional jumps.
// ----------------------------------------------------------------------------
module pds_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  pds_pkg::pds_flags_type flags,
   output pds_pkg::pds_ctrl_type  ctrl,
   output logic                 busy
);
   import pds_pkg::*;

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic            take;

   always_comb begin
      case (pc_ff)
         5'd0:  ctrl = '{OP_IDLE,      COND_IDLE,   PC_IDLE};
         5'd1:  ctrl = '{OP_WANT,      COND_NEVER,  PC_IDLE};
         5'd2:  ctrl = '{OP_X_WANT,    COND_NEVER,  PC_IDLE};
         5'd3:  ctrl = '{OP_DIV_MUL,   COND_NEVER,  PC_IDLE};
         5'd4:  ctrl = '{OP_DIV_REM,   COND_NEVER,  PC_IDLE};
         5'd5:  ctrl = '{OP_DIV_FIX,   COND_NEVER,  PC_IDLE};
         5'd6:  ctrl = '{OP_SAVE_STEP, COND_NEVER,  PC_IDLE};
         5'd7:  ctrl = '{OP_X_P0,      COND_NEVER,  PC_IDLE};
         5'd8:  ctrl = '{OP_DIV_MUL,   COND_NEVER,  PC_IDLE};
         5'd9:  ctrl = '{OP_DIV_REM,   COND_NEVER,  PC_IDLE};
         5'd10: ctrl = '{OP_DIV_FIX,   COND_NEVER,  PC_IDLE};
         5'd11: ctrl = '{OP_INIT_D,    COND_NEVER,  PC_IDLE};
         5'd12: ctrl = '{OP_SCAN,      COND_SCAN,   PC_SCAN};
         5'd13: ctrl = '{OP_NOP,       COND_MATCH,  PC_HIT};
         5'd14: ctrl = '{OP_NEXT_TRY,  COND_TRY,    PC_TRY};
         5'd15: ctrl = '{OP_MISS,      COND_ALWAYS, PC_IDLE};
         5'd16: ctrl = '{OP_HIT,       COND_ALWAYS, PC_IDLE};
         default: ctrl = '{OP_NOP,     COND_ALWAYS, PC_IDLE};
      endcase
   end

   always_comb begin
      case (ctrl.cond)
         COND_NEVER:  take = 1'b0;
         COND_ALWAYS: take = 1'b1;
         COND_IDLE:   take = !start;
         COND_SCAN:   take = !flags.match && flags.more_d;
         COND_MATCH:  take = flags.match;
         COND_TRY:    take = flags.more_try;
         default:     take = 1'b1;
      endcase
      pc_in = take ? ctrl.target : pc_ff + 5'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign busy = (pc_ff != PC_IDLE);

endmodule

/* rtl/pds_datapath.sv */
// ----------------------------------------------------------------------------
// pds_datapath
// Target scaling, divide-by-2500 unit, incremental divider scan, result register.
// ----------------------------------------------------------------------------
module pds_datapath #(
   parameter int MAX_DIVIDER = pds_pkg::DEF_MAX_DIVIDER,
   parameter int MAX_MULTIPLIER = pds_pkg::DEF_MAX_MULTIPLIER,
   parameter int TRY_COUNT = pds_pkg::DEF_TRY_COUNT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [pds_pkg::TARGET_W-1:0]  target_mhz,
   input  pds_pkg::pds_ctrl_type         ctrl,
   output pds_pkg::pds_flags_type        flags,
   output logic                          rsp_strobe,
   output logic [15:0]                   rsp_pll_word,
   output logic                          rsp_found
);
   import pds_pkg::*;

   localparam logic [7:0] MAX_D = MAX_DIVIDER[7:0];
   localparam logic [Q_W-1:0] MAX_M = Q_W'(MAX_MULTIPLIER);
   localparam logic [TRY_W:0] TRIES = (TRY_W + 1)'(TRY_COUNT);

   logic [TARGET_W-1:0] target_ff, target_in;
   logic [TRY_W-1:0]    try_ff, try_in;
   logic [WANT_W-1:0]   want_ff, want_in;
   logic [X_W-1:0]      x_ff, x_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [Q_W-1:0]      q_ff, q_in;
   logic [R_W-1:0]      r_ff, r_in;
   logic [Q_W-1:0]      wq_ff, wq_in;
   logic [R_W-1:0]      wr_ff, wr_in;
   logic [7:0]          d_ff, d_in;
   logic                strobe_ff, strobe_in;
   logic [15:0]         word_ff, word_in;
   logic                found_ff, found_in;

   logic [SUM_W-1:0]    sum;
   logic [FULL_W-1:0]   rem_full;
   logic [R_W:0]        diff;
   logic                borrow;

   always_comb begin
      sum = {1'b0, target_ff} + SUM_W'(try_ff);
      rem_full = FULL_W'(x_ff) - FULL_W'(prod_ff[RECIP_SHIFT +: Q_W]) * FULL_W'(MOD_CENTI);
      diff = {1'b0, r_ff} - {1'b0, wr_ff};
      borrow = diff[R_W];
      flags.match = (q_ff != '0) && (q_ff <= MAX_M) && (r_ff < R_W'(d_ff));
      flags.more_d = (d_ff > MIN_DIVIDER);
      flags.more_try = ({1'b0, try_ff} + (TRY_W + 1)'(1)) < TRIES;
   end

   always_comb begin
      target_in = target_ff;
      try_in = try_ff;
      want_in = want_ff;
      x_in = x_ff;
      prod_in = prod_ff;
      q_in = q_ff;
      r_in = r_ff;
      wq_in = wq_ff;
      wr_in = wr_ff;
      d_in = d_ff;
      strobe_in = 1'b0;
      word_in = word_ff;
      found_in = found_ff;
      case (ctrl.op)
         OP_IDLE: begin
            if (accept) begin
               target_in = target_mhz;
               try_in = '0;
            end
         end
         OP_WANT: want_in = WANT_W'(sum) * CENTI;
         OP_X_WANT: x_in = X_W'(want_ff);
         OP_X_P0: x_in = X_W'(MAX_D) * X_W'(want_ff);
         OP_DIV_MUL: prod_in = PROD_W'(x_ff[X_W-1:2]) * PROD_W'(RECIP);
         OP_DIV_REM: begin
            q_in = prod_ff[RECIP_SHIFT +: Q_W];
            r_in = rem_full[R_W-1:0];
         end
         OP_DIV_FIX: begin
            if (r_ff >= MOD_CENTI) begin
               r_in = r_ff - MOD_CENTI;
               q_in = q_ff + Q_W'(1);
            end
         end
         OP_SAVE_STEP: begin
            wq_in = q_ff;
            wr_in = r_ff;
         end
         OP_INIT_D: d_in = MAX_D;
         OP_SCAN: begin
            if (!flags.match && flags.more_d) begin
               d_in = d_ff - 8'd1;
               q_in = q_ff - wq_ff - Q_W'(borrow);
               r_in = borrow ? diff[R_W-1:0] + MOD_CENTI : diff[R_W-1:0];
            end
         end
         OP_NEXT_TRY: try_in = try_ff + TRY_W'(1);
         OP_HIT: begin
            strobe_in = 1'b1;
            word_in = {q_ff[7:0], d_ff};
            found_in = 1'b1;
         end
         OP_MISS: begin
            strobe_in = 1'b1;
            word_in = '0;
            found_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      try_ff <= try_in;
      want_ff <= want_in;
      x_ff <= x_in;
      prod_ff <= prod_in;
      q_ff <= q_in;
      r_ff <= r_in;
      wq_ff <= wq_in;
      wr_ff <= wr_in;
      d_ff <= d_in;
      word_ff <= word_in;
      found_ff <= found_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_pll_word = word_ff;
   assign rsp_found = found_ff;

endmodule
